FILE: design/delta_rice_encoder_macros.svh
// ----------------------------------------------------------------------------
// delta_rice_encoder_macros.svh
// Assertion macros used by the delta Rice encoder checker.
// ----------------------------------------------------------------------------
`ifndef DELTA_RICE_ENCODER_MACROS_SVH
`define DELTA_RICE_ENCODER_MACROS_SVH

// Same-cycle implication, off while reset is high
`define DRE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("delta_rice_encoder: check failed");

// Next-cycle implication, off while reset is high
`define DRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("delta_rice_encoder: check failed");

`endif

FILE: design/dre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dre_pkg
// Types and constants of the delta Rice encoder.
// ----------------------------------------------------------------------------
package dre_pkg;

   localparam int VALUE_W       = 32;
   localparam int SHIFT_W       = 5;
   localparam int CODE_W        = 64;
   localparam int MAX_CODE_BITS = 64;
   localparam int LENGTH_W      = $clog2(MAX_CODE_BITS + 1);
   localparam int STATUS_W      = 2;

   localparam logic [SHIFT_W-1:0] RICE_SHIFT_RESET = SHIFT_W'(2);

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DECREASED = 2'd1,
      STATUS_TOO_LONG  = 2'd2
   } status_type;

   // item after the input register: delta and the shift it was taken with
   typedef struct packed {
      logic [VALUE_W-1:0] diff;
      logic               decreased;
      logic [SHIFT_W-1:0] shift;
   } stage_type;

   // finished code for one item
   typedef struct packed {
      logic [CODE_W-1:0]   code_word;
      logic [LENGTH_W-1:0] code_length;
      status_type          status;
   } result_type;

endpackage

FILE: design/dre_code.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dre_code
// Forms the Rice code word, its length and status from one registered delta.
// ----------------------------------------------------------------------------
module dre_code (
   input  dre_pkg::stage_type  stage,
   output dre_pkg::result_type result
);
   import dre_pkg::*;

   logic [VALUE_W-1:0]   quotient;
   logic [VALUE_W+1:0]   total;
   logic                 too_long;
   logic [LENGTH_W-1:0]  total_len;
   logic [LENGTH_W-1:0]  rem_len;
   logic [CODE_W-1:0]    ones;
   logic [CODE_W-1:0]    rem;

   // mask of the n low bits, n up to CODE_W
   function automatic logic [CODE_W-1:0] low_mask(input logic [LENGTH_W-1:0] n);
      logic [CODE_W:0] full;
      full = ((CODE_W+1)'(1) << n) - (CODE_W+1)'(1);
      return full[CODE_W-1:0];
   endfunction

   // quotient and total code length q + 1 + k
   assign quotient  = stage.diff >> stage.shift;
   assign total     = (VALUE_W+2)'(quotient) + (VALUE_W+2)'(stage.shift) + (VALUE_W+2)'(1);
   assign too_long  = total > (VALUE_W+2)'(MAX_CODE_BITS);
   assign total_len = total[LENGTH_W-1:0];
   assign rem_len   = LENGTH_W'(stage.shift);

   // unary ones sit between bit k+1 and the top of the code; bit k is the zero
   assign ones = low_mask(total_len) & ~low_mask(rem_len + LENGTH_W'(1));
   assign rem  = CODE_W'(stage.diff) & low_mask(rem_len);

   always_comb begin
      result.code_word   = '0;
      result.code_length = '0;
      result.status      = STATUS_OK;
      if (stage.decreased) begin
         result.status = STATUS_DECREASED;
      end else if (too_long) begin
         result.status = STATUS_TOO_LONG;
      end else begin
         result.code_word   = ones | rem;
         result.code_length = total_len;
      end
   end

endmodule

FILE: design/delta_rice_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_rice_encoder
// Delta plus Rice (power-of-two Golomb) coder for ascending 32-bit values.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_stall is low and returns one result per
// item: the delta from the previous value is formed into the input register,
// then the code is built into the result register. Stall flows back through
// the two-register pipeline from the result side. rice_shift is sampled when
// an item is accepted; a decreasing value or a code over 64 bits gives a status
// and an empty code, and the value still becomes the new previous value.
module delta_rice_encoder (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [dre_pkg::SHIFT_W-1:0]   csr_wr_data,
   // input item
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dre_pkg::VALUE_W-1:0]   req_value,
   // result item
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dre_pkg::CODE_W-1:0]    rsp_code_word,
   output logic [dre_pkg::LENGTH_W-1:0]  rsp_code_length,
   output logic [dre_pkg::STATUS_W-1:0]  rsp_status
);
   import dre_pkg::*;

   logic [SHIFT_W-1:0] rice_shift_ff;
   logic [VALUE_W-1:0] prev_value_ff;
   logic               stage_valid_ff;
   stage_type          stage_ff;
   stage_type          stage_in;
   logic               rsp_valid_ff;
   result_type         result_ff;
   result_type         result_in;
   logic               rsp_load;
   logic               stage_load;
   logic               req_take;

   // pipeline enables: each register moves when its downstream is free
   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign stage_load = !stage_valid_ff || rsp_load;
   assign req_take   = req_valid && stage_load;
   assign req_stall  = !stage_load;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         rice_shift_ff <= RICE_SHIFT_RESET;
      end else if (csr_wr_en) begin
         rice_shift_ff <= csr_wr_data;
      end
   end

   // delta against the previous value
   always_comb begin
      stage_in.diff      = req_value - prev_value_ff;
      stage_in.decreased = req_value < prev_value_ff;
      stage_in.shift     = rice_shift_ff;
   end

   // input register and previous value
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_value_ff  <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            prev_value_ff <= req_value;
         end
         if (stage_load) begin
            stage_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= stage_in;
      end
   end

   // code formation
   dre_code u_code (
      .stage  (stage_ff),
      .result (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && stage_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_word   = result_ff.code_word;
   assign rsp_code_length = result_ff.code_length;
   assign rsp_status      = result_ff.status;

endmodule

FILE: design/dre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dre_checker
// Port-level checks of the delta Rice encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "delta_rice_encoder_macros.svh"

module dre_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [dre_pkg::CODE_W-1:0]    rsp_code_word,
   input  logic [dre_pkg::LENGTH_W-1:0]  rsp_code_length,
   input  logic [dre_pkg::STATUS_W-1:0]  rsp_status
);
   import dre_pkg::*;

   logic status_ok;

   assign status_ok = rsp_status == STATUS_OK;

   // a stalled result item holds
   `DRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_code_word) && $stable(rsp_code_length) && $stable(rsp_status))

   // an error result carries an empty code
   `DRE_ASSERT_NOW(a_err_empty, clock, reset, rsp_valid && !status_ok,
      rsp_code_length == '0 && rsp_code_word == '0)

   // a good code has at least the separator bit and fits the word
   `DRE_ASSERT_NOW(a_ok_length, clock, reset, rsp_valid && status_ok,
      rsp_code_length != '0 && rsp_code_length <= LENGTH_W'(MAX_CODE_BITS))

   // no code bits stand above the code length
   `DRE_ASSERT_NOW(a_ok_fits, clock, reset, rsp_valid && status_ok,
      (rsp_code_word >> rsp_code_length) == '0)

endmodule

bind delta_rice_encoder dre_checker u_dre_checker (.*);

FILE: tb/delta_rice_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_rice_encoder_test
// Self-checking bench for the delta Rice encoder. Values go in through the
// req_ channel and each one is coded on the bench side from its own copy of
// the previous value and rice_shift. Codes coming out of the rsp_ channel are
// compared in order against that queue. Directed cases cover the length limit
// at several shifts, the unary-only code, the widest remainder, decreasing
// values and the running delta after an error. Random ascending streams then
// run under four pacing modes on both handshakes.
// ----------------------------------------------------------------------------
module delta_rice_encoder_test;
   import dre_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 7;
   localparam int STALL_LIMIT  = 2000;  // cycles with no item moving
   localparam int DRAIN_CYCLES = 4;     // pipeline is two deep
   localparam int BLOCK_ITEMS  = 44;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                csr_wr_en       = 1'b0;
   logic [SHIFT_W-1:0]  csr_wr_data     = '0;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [VALUE_W-1:0]  req_value       = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [CODE_W-1:0]   rsp_code_word;
   logic [LENGTH_W-1:0] rsp_code_length;
   logic [STATUS_W-1:0] rsp_status;

   // bench copy of the coder state
   logic [VALUE_W-1:0]  last_value = '0;
   logic [SHIFT_W-1:0]  code_shift = RICE_SHIFT_RESET;
   result_type          pending_codes[$];

   // stimulus side
   logic [VALUE_W-1:0]  sent_last = '0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  items_sent = 0;
   int                  directed_items = 0;
   int                  shift_writes = 0;

   // checker side
   int                  error_count = 0;
   int                  codes_ok = 0;
   int                  codes_decreased = 0;
   int                  codes_too_long = 0;
   int                  quiet_cycles = 0;
   result_type          want;

   delta_rice_encoder uut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_word   (rsp_code_word),
      .rsp_code_length (rsp_code_length),
      .rsp_status      (rsp_status)
   );

   always #HALF_PERIOD clock = ~clock;

   // Rice code of the delta: q ones, a zero, then k remainder bits
   function automatic result_type rice_code_of(logic [VALUE_W-1:0] cur,
                                               logic [VALUE_W-1:0] prev,
                                               logic [SHIFT_W-1:0] k);
      result_type  r;
      logic [63:0] diff;
      logic [63:0] q;
      logic [63:0] total;
      logic [63:0] ones;
      r = '0;
      r.status = STATUS_OK;
      if (cur < prev) begin
         r.status = STATUS_DECREASED;
      end else begin
         diff  = 64'(cur - prev);
         q     = diff >> k;
         total = q + 64'd1 + 64'(k);
         if (total > 64'(MAX_CODE_BITS)) begin
            r.status = STATUS_TOO_LONG;
         end else begin
            ones          = (64'd1 << q) - 64'd1;
            r.code_word   = (ones << (k + 1)) | (diff & ((64'd1 << k) - 64'd1));
            r.code_length = total[LENGTH_W-1:0];
         end
      end
      return r;
   endfunction

   // next value for a random stream: mostly ascending, some noise
   function automatic logic [VALUE_W-1:0] next_stream_value(logic [VALUE_W-1:0] prev,
                                                            logic [SHIFT_W-1:0] k);
      int          pick;
      logic [63:0] span;
      logic [63:0] sum;
      pick = $urandom_range(99);
      if (pick < 80) begin
         // short steps keep codes small, long ones probe the length limit
         span = (pick < 40) ? (64'd4 << k) : (64'd66 << k);
         if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
         sum = 64'(prev) + ({$urandom, $urandom} % (span + 64'd1));
         if (sum > 64'hFFFF_FFFF)
            return VALUE_W'($urandom_range(255));
         return sum[VALUE_W-1:0];
      end
      if (pick < 90)
         return $urandom;
      return prev - VALUE_W'($urandom_range(3));
   endfunction

   // present one value, holding it until the coder takes it
   task automatic send_value(input logic [VALUE_W-1:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do
         @(posedge clock);
      while (req_stall);
      sent_last = v;
      items_sent++;
   endtask

   // stop sending and let every pending code come out
   task automatic wait_for_drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // rice_shift write, only with the coder idle
   task automatic set_rice_shift(input logic [SHIFT_W-1:0] k);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      code_shift = k;
      shift_writes++;
   endtask

   task automatic send_directed(input logic [VALUE_W-1:0] v);
      send_value(v);
      directed_items++;
   endtask

   // reset shift of 2: zero delta, exact 64-bit code, overflow, decrease,
   // and the delta restarting from the value that failed
   task automatic test_reset_shift_codes;
      send_directed(32'd0);
      send_directed(32'd0);
      send_directed(32'd1);
      send_directed(32'd7);
      send_directed(32'd250);
      send_directed(32'd497);          // delta 247: length 64
      send_directed(32'd745);          // delta 248: too long
      send_directed(32'd100);          // decreased
      send_directed(32'd101);          // delta 1 from the bad value
      send_directed(32'hFFFF_FFFF);    // huge delta
      send_directed(32'd0);            // largest drop
   endtask

   // shift 0 gives a unary code with no remainder bits
   task automatic test_unary_only;
      set_rice_shift(SHIFT_W'(0));
      send_directed(32'd1000);
      send_directed(32'd1000);
      send_directed(32'd1063);         // 63 ones then zero: length 64
      send_directed(32'd1127);         // 64 ones: too long
      send_directed(32'd1128);
   endtask

   // widest remainder: 31 bits, quotient at most 1
   task automatic test_widest_remainder;
      set_rice_shift(SHIFT_W'(31));
      send_directed(32'd0);
      send_directed(32'hFFFF_FFFF);
      send_directed(32'hFFFF_FFFF);
      send_directed(32'h8000_0000);
   endtask

   // shift 1: length limit one step either side
   task automatic test_length_limit_k1;
      set_rice_shift(SHIFT_W'(1));
      send_directed(32'd0);
      send_directed(32'd125);          // q 62: length 64
      send_directed(32'd251);          // q 63: too long
      send_directed(32'd252);
   endtask

   // random streams under each pacing mode and three shifts per mode
   task automatic test_random_streams;
      int                 sender_pct[4];
      int                 receiver_pct[4];
      logic [SHIFT_W-1:0] k;
      sender_pct   = '{0, 53, 0, 9};
      receiver_pct = '{0, 0, 53, 9};
      for (int mode = 0; mode < 4; mode++) begin
         for (int blk = 0; blk < 3; blk++) begin
            k = SHIFT_W'($urandom_range(1, 31));
            if (blk == 0)
               k = (mode % 2 == 0) ? SHIFT_W'(1) : SHIFT_W'(31);
            set_rice_shift(k);
            send_idle_pct = sender_pct[mode];
            stall_pct     = receiver_pct[mode];
            for (int n = 0; n < BLOCK_ITEMS; n++)
               send_value(next_stream_value(sent_last, k));
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // receiver pacing and the no-progress watchdog
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d codes pending",
                  $time, quiet_cycles, pending_codes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // code each accepted value, then check each accepted result in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_codes = {pending_codes,
                             rice_code_of(req_value, last_value, code_shift)};
            last_value = req_value;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_codes.size() == 0) begin
               $display("%0t: unexpected code: word %h length %0d status %0d",
                        $time, rsp_code_word, rsp_code_length, rsp_status);
               error_count++;
            end else begin
               want = pending_codes.pop_front();
               if (rsp_code_word !== want.code_word) begin
                  $display("%0t: code_word expected %h got %h",
                           $time, want.code_word, rsp_code_word);
                  error_count++;
               end
               if (rsp_code_length !== want.code_length) begin
                  $display("%0t: code_length expected %0d got %0d",
                           $time, want.code_length, rsp_code_length);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_status);
                  error_count++;
               end
               case (want.status)
                  STATUS_OK:        codes_ok++;
                  STATUS_DECREASED: codes_decreased++;
                  default:          codes_too_long++;
               endcase
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_shift_codes();
      test_unary_only();
      test_widest_remainder();
      test_length_limit_k1();
      test_random_streams();
      wait_for_drain();
      $display("Coded %0d values (%0d directed) across %0d rice_shift writes and",
               items_sent, directed_items, shift_writes);
      $display("four pacing modes: %0d ok, %0d decreasing, %0d over length",
               codes_ok, codes_decreased, codes_too_long);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: delta_rice_encoder.f
+incdir+design
design/dre_pkg.sv
design/dre_code.sv
design/delta_rice_encoder.sv
design/dre_checker.sv
tb/delta_rice_encoder_test.sv
